// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/cps_pkg.sv
package cps_pkg;

   localparam int TASK_SLOTS   = 16;
   localparam int SLOT_W       = $clog2(TASK_SLOTS);
   localparam int CNT_W        = $clog2(TASK_SLOTS + 1);
   localparam int FUNC_W       = 2;
   localparam int SLOT_FIELD_W = 4;
   localparam int PRIO_W       = 7;
   localparam int SLICE_W      = 8;
   localparam int STATUS_W     = 2;
   localparam int SLICE_MAX    = 2 ** SLICE_W - 1;

   typedef enum logic [FUNC_W-1:0] {
      FN_TICK,
      FN_ADD,
      FN_SET,
      FN_NONE
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_FULL,
      ST_NORUN,
      ST_BADSLOT
   } status_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_MARK,
      OP_DEC,
      OP_RECOMP
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [PRIO_W-1:0]  prio;
      logic               mark;
   } cell_cmd_type;

   // Wavefront that walks the chain, one cell per cycle.
   typedef struct packed {
      logic               valid;
      logic [SLOT_W-1:0]  best;
      logic [SLICE_W-1:0] top;
      logic               any;
   } scan_type;

endpackage

// File: hw/rtl/cps_if.sv
interface cps_req_if import cps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic [SLOT_FIELD_W-1:0] task_slot;
   logic [PRIO_W-1:0]       priority_req;
   logic                    runnable;

   modport source (output valid, func, task_slot, priority_req, runnable, input ready);
   modport sink   (input valid, func, task_slot, priority_req, runnable, output ready);
endinterface

interface cps_rsp_if import cps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SLOT_FIELD_W-1:0] current_task;
   logic                    switched;
   logic [SLICE_W-1:0]      remaining;
   logic [SLOT_FIELD_W-1:0] new_task;
   logic [STATUS_W-1:0]     status;

   modport source (output valid, current_task, switched, remaining, new_task, status,
                   input ready);
   modport sink   (input valid, current_task, switched, remaining, new_task, status,
                   output ready);
endinterface

// File: hw/rtl/counter_priority_scheduler_top.sv
// Counter/priority time-slice scheduler over TASK_SLOTS task slots, slot 0 being the idle
// task. Every other slot lives in one cell of a chain; a reschedule sends a search
// wavefront down the chain one cell per cycle, and a recompute of all counters happens
// in every cell at once. One item is worked at a time: add, set, unused codes and ticks
// that do not reschedule go through the done state to the response register; a tick
// that reschedules waits in the scan state for the wavefront, and when every runnable
// counter was zero runs a recompute pass and a second scan. A new beat may be taken
// while the previous result still waits on the rsp side.
`include "assert_macros.svh"

module counter_priority_scheduler_top import cps_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cps_req_if.sink   req_bus,
   cps_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RECOMP,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        task_count_ff, task_count_in;
   logic [SLOT_W-1:0]       running_ff, running_in;
   logic [SLOT_W-1:0]       before_ff, before_in;
   logic [SLOT_W-1:0]       added_ff, added_in;
   status_type              status_ff, status_in;
   logic                    pass_ff, pass_in;
   logic                    launch_ff, launch_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SLOT_FIELD_W-1:0] rsp_task_ff, rsp_task_in;
   logic                    rsp_switched_ff, rsp_switched_in;
   logic [SLICE_W-1:0]      rsp_remaining_ff, rsp_remaining_in;
   logic [SLOT_FIELD_W-1:0] rsp_new_ff, rsp_new_in;
   status_type              rsp_status_ff, rsp_status_in;

   cell_cmd_type       cmd;
   logic [SLOT_W-1:0]  sel_slot;
   logic [SLICE_W-1:0] slices [TASK_SLOTS];
   scan_type           chain [TASK_SLOTS];
   scan_type           tail;
   logic [SLICE_W-1:0] cur_slice;
   logic [CNT_W-1:0]   count_next;
   logic               accept;

   assign chain[0]  = '{valid: launch_ff, best: '0, top: '0, any: 1'b0};
   assign slices[0] = '0;
   assign tail      = chain[TASK_SLOTS-1];

   for (genvar g = 1; g < TASK_SLOTS; g++) begin : g_cell
      cps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .slot_id   (SLOT_W'(g)),
         .cmd       (cmd),
         .sel       (sel_slot == SLOT_W'(g)),
         .scan_in   (chain[g-1]),
         .scan_out  (chain[g]),
         .slice_out (slices[g])
      );
   end

   assign cur_slice      = slices[running_ff];
   assign count_next     = task_count_ff + CNT_W'(1);
   assign req_bus.ready  = (state_ff == S_IDLE);
   assign accept         = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in         = state_ff;
      task_count_in    = task_count_ff;
      running_in       = running_ff;
      before_in        = before_ff;
      added_in         = added_ff;
      status_in        = status_ff;
      pass_in          = pass_ff;
      launch_in        = 1'b0;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_task_in      = rsp_task_ff;
      rsp_switched_in  = rsp_switched_ff;
      rsp_remaining_in = rsp_remaining_ff;
      rsp_new_in       = rsp_new_ff;
      rsp_status_in    = rsp_status_ff;
      cmd.op           = OP_NOP;
      cmd.prio         = req_bus.priority_req;
      cmd.mark         = req_bus.runnable;
      sel_slot         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               before_in = running_ff;
               added_in  = '0;
               status_in = ST_OK;
               pass_in   = 1'b0;
               state_in  = S_DONE;
               unique case (func_type'(req_bus.func))
                  FN_TICK: begin
                     if (cur_slice == '0) begin
                        state_in  = S_SCAN;
                        launch_in = 1'b1;
                     end else begin
                        cmd.op   = OP_DEC;
                        sel_slot = running_ff;
                        if (cur_slice == SLICE_W'(1)) begin
                           state_in  = S_SCAN;
                           launch_in = 1'b1;
                        end
                     end
                  end
                  FN_ADD: begin
                     if (count_next >= CNT_W'(TASK_SLOTS)) begin
                        status_in = ST_FULL;
                     end else begin
                        task_count_in = count_next;
                        cmd.op        = OP_LOAD;
                        sel_slot      = SLOT_W'(count_next);
                        added_in      = SLOT_W'(count_next);
                     end
                  end
                  FN_SET: begin
                     if (req_bus.task_slot == '0 ||
                         CNT_W'(req_bus.task_slot) > task_count_ff) begin
                        status_in = ST_BADSLOT;
                     end else begin
                        cmd.op   = OP_MARK;
                        sel_slot = SLOT_W'(req_bus.task_slot);
                     end
                  end
                  FN_NONE: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (tail.valid) begin
               if (tail.best != '0) begin
                  running_in = tail.best;
                  state_in   = S_DONE;
               end else if (!tail.any || pass_ff) begin
                  running_in = '0;
                  status_in  = ST_NORUN;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_RECOMP;
               end
            end
         end
         S_RECOMP: begin
            cmd.op    = OP_RECOMP;
            launch_in = 1'b1;
            pass_in   = 1'b1;
            state_in  = S_SCAN;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_task_in      = SLOT_FIELD_W'(running_ff);
               rsp_switched_in  = (running_ff != before_ff);
               rsp_remaining_in = cur_slice;
               rsp_new_in       = SLOT_FIELD_W'(added_ff);
               rsp_status_in    = status_ff;
               state_in         = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         task_count_ff <= '0;
         running_ff    <= '0;
         pass_ff       <= 1'b0;
         launch_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         task_count_ff <= task_count_in;
         running_ff    <= running_in;
         pass_ff       <= pass_in;
         launch_ff     <= launch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      before_ff        <= before_in;
      added_ff         <= added_in;
      status_ff        <= status_in;
      rsp_task_ff      <= rsp_task_in;
      rsp_switched_ff  <= rsp_switched_in;
      rsp_remaining_ff <= rsp_remaining_in;
      rsp_new_ff       <= rsp_new_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.current_task = rsp_task_ff;
   assign rsp_bus.switched     = rsp_switched_ff;
   assign rsp_bus.remaining    = rsp_remaining_ff;
   assign rsp_bus.new_task     = rsp_new_ff;
   assign rsp_bus.status       = rsp_status_ff;

   `ASSERT_ALWAYS(a_run_in_table, clock, reset, CNT_W'(running_ff) <= task_count_ff, "running slot beyond table")
   `ASSERT_NEXT(a_count_grows, clock, reset, 1'b1, task_count_ff >= $past(task_count_ff), "task count shrank")
   `ASSERT_ALWAYS(a_scan_quiet, clock, reset, !tail.valid || state_ff == S_SCAN, "scan beat outside scan state")

endmodule

// File: hw/rtl/cps_cell.sv
module cps_cell import cps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [SLOT_W-1:0]  slot_id,
   input  cell_cmd_type       cmd,
   input  logic               sel,
   input  scan_type           scan_in,
   output scan_type           scan_out,
   output logic [SLICE_W-1:0] slice_out
);

   logic [PRIO_W-1:0]  prio_ff, prio_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   logic               ready_ff, ready_in;
   scan_type           scan_ff, scan_in_nxt;
   logic [SLICE_W:0]   sum;
   logic               wins;

   assign sum  = {1'b0, slice_ff >> 1} + (SLICE_W + 1)'(prio_ff);
   assign wins = ready_ff && (slice_ff > scan_in.top);

   always_comb begin
      prio_in  = prio_ff;
      slice_in = slice_ff;
      ready_in = ready_ff;
      case (cmd.op)
         OP_LOAD: begin
            if (sel) begin
               prio_in  = cmd.prio;
               slice_in = '0;
               ready_in = 1'b1;
            end
         end
         OP_MARK: begin
            if (sel) begin
               ready_in = cmd.mark;
            end
         end
         OP_DEC: begin
            if (sel) begin
               slice_in = slice_ff - SLICE_W'(1);
            end
         end
         OP_RECOMP: begin
            slice_in = (sum > (SLICE_W + 1)'(SLICE_MAX)) ? '1 : sum[SLICE_W-1:0];
         end
         default: begin
         end
      endcase

      scan_in_nxt       = scan_in;
      scan_in_nxt.any   = scan_in.any | ready_ff;
      if (wins) begin
         scan_in_nxt.best = slot_id;
         scan_in_nxt.top  = slice_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_ff       <= '0;
         slice_ff      <= '0;
         ready_ff      <= 1'b0;
         scan_ff.valid <= 1'b0;
      end else begin
         prio_ff       <= prio_in;
         slice_ff      <= slice_in;
         ready_ff      <= ready_in;
         scan_ff.valid <= scan_in_nxt.valid;
      end
      scan_ff.best <= scan_in_nxt.best;
      scan_ff.top  <= scan_in_nxt.top;
      scan_ff.any  <= scan_in_nxt.any;
   end

   assign scan_out  = scan_ff;
   assign slice_out = slice_ff;

endmodule
